// File: hw/rtl/apnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_pkg
// Shared types, constants and field helpers for the affine point and normal
// transform pipeline.
// ----------------------------------------------------------------------------
package apnt_pkg;

  localparam int POINT_W_DEF  = 28;
  localparam int NORMAL_W_DEF = 16;

  localparam int COEF_W      = 16;
  localparam int ROW_W       = 3 * COEF_W;
  localparam int PACK_W      = 21;
  localparam int PACK3_W     = 3 * PACK_W;
  localparam int CFG_IDX_W   = 3;
  localparam int OFF_SHIFT   = 4;
  localparam int TRANS_SHIFT = 18;
  localparam int RND_SHIFT   = 14;

  localparam int MAG_W = 30;
  localparam int SQ_W  = 2 * MAG_W + 2;
  localparam int LEN_W = SQ_W / 2;

  localparam int PNT_LAT = 3;
  localparam int ROT_LAT = 7;
  localparam int ISQ_LAT = LEN_W;

  localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(16384);
  localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(16384) << COEF_W;
  localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(16384) << (2 * COEF_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_Z  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_X  = 3'd2,
    REG_TRANS  = 3'd3,
    REG_OFFSET = 3'd4,
    REG_OFF_EN = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_z;
    logic [ROW_W-1:0]   row_y;
    logic [ROW_W-1:0]   row_x;
    logic [PACK3_W-1:0] trans;
    logic [PACK3_W-1:0] offset;
    logic               off_en;
  } xform_cfg_t;

  function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                       input int unsigned col);
    return row[col*COEF_W +: COEF_W];
  endfunction

  function automatic logic signed [PACK_W-1:0] pack_of(input logic [PACK3_W-1:0] v,
                                                       input int unsigned k);
    return v[k*PACK_W +: PACK_W];
  endfunction

endpackage

// File: hw/rtl/apnt_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_point
// Point path: optional offset add, 3x4 matrix product, rounding and
// saturation, then a delay line that aligns the result with the normal path.
// ----------------------------------------------------------------------------
module apnt_point import apnt_pkg::*; #(
  parameter int PW  = POINT_W_DEF,
  parameter int DLY = 1
) (
  input  logic                 clk,
  input  xform_cfg_t           cfg,
  input  logic signed [PW-1:0] point_x,
  input  logic signed [PW-1:0] point_y,
  input  logic signed [PW-1:0] point_z,
  input  logic                 point_ok,
  output logic signed [PW-1:0] res_x,
  output logic signed [PW-1:0] res_y,
  output logic signed [PW-1:0] res_z,
  output logic                 res_ok
);

  localparam int AW = ((PW > PACK_W + OFF_SHIFT) ? PW : PACK_W + OFF_SHIFT) + 1;
  localparam int MW = AW + COEF_W;
  localparam int SW = MW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(2 ** (RND_SHIFT - 1));

  logic signed [PW-1:0] p_in [3];
  logic [ROW_W-1:0]     rows [3];

  logic signed [PW-1:0] p1 [3];
  logic signed [PW-1:0] p2 [3];
  logic signed [PW-1:0] p3 [3];
  logic                 ok1, ok2, ok3;
  logic signed [AW-1:0] a1 [3];
  logic signed [MW-1:0] m2 [3][3];
  logic signed [SW-1:0] s3 [3];
  logic signed [SW-1:0] rnd [3];
  logic signed [PW-1:0] fin [3];

  logic signed [PW-1:0] dx [DLY][3];
  logic                 dok [DLY];

  function automatic logic signed [PW-1:0] sat_pw(input logic signed [SW-1:0] v);
    logic hi_ones;
    logic hi_zero;
    hi_ones = &v[SW-1:PW-1];
    hi_zero = ~|v[SW-1:PW-1];
    if (hi_ones || hi_zero) return v[PW-1:0];
    else if (v[SW-1]) return {1'b1, {(PW-1){1'b0}}};
    else return {1'b0, {(PW-1){1'b1}}};
  endfunction

  assign p_in[0] = point_x;
  assign p_in[1] = point_y;
  assign p_in[2] = point_z;
  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;

  always_ff @(posedge clk) begin
    ok1 <= point_ok;
    ok2 <= ok1;
    ok3 <= ok2;
    for (int i = 0; i < 3; i++) begin
      p1[i] <= p_in[i];
      p2[i] <= p1[i];
      p3[i] <= p2[i];
      a1[i] <= AW'(p_in[i]) +
               (cfg.off_en ? (AW'(pack_of(cfg.offset, i)) <<< OFF_SHIFT) : AW'(0));
    end
    for (int o = 0; o < 3; o++) begin
      for (int i = 0; i < 3; i++) begin
        m2[o][i] <= MW'(a1[i]) * MW'(coef_of(rows[o], 2 - i));
      end
      s3[o] <= (SW'(pack_of(cfg.trans, 2 - o)) <<< TRANS_SHIFT) +
               SW'(m2[o][0]) + SW'(m2[o][1]) + SW'(m2[o][2]);
    end
  end

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      rnd[o] = (s3[o] + HALF) >>> RND_SHIFT;
      fin[o] = ok3 ? sat_pw(rnd[o]) : p3[o];
    end
  end

  always_ff @(posedge clk) begin
    dok[0] <= ok3;
    for (int o = 0; o < 3; o++) dx[0][o] <= fin[o];
    for (int k = 1; k < DLY; k++) begin
      dok[k] <= dok[k-1];
      for (int o = 0; o < 3; o++) dx[k][o] <= dx[k-1][o];
    end
  end

  assign res_x  = dx[DLY-1][0];
  assign res_y  = dx[DLY-1][1];
  assign res_z  = dx[DLY-1][2];
  assign res_ok = dok[DLY-1];

endmodule

// File: hw/rtl/apnt_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_rotate
// Normal front end: 3x3 rotation, magnitudes, common normalizing shift,
// squares and their sum.
// ----------------------------------------------------------------------------
module apnt_rotate import apnt_pkg::*; #(
  parameter int NW = NORMAL_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  xform_cfg_t            cfg,
  input  logic signed [NW-1:0]  normal_x,
  input  logic signed [NW-1:0]  normal_y,
  input  logic signed [NW-1:0]  normal_z,
  input  logic                  normal_ok,
  output logic                  out_vld,
  output logic [MAG_W-1:0]      mag_x,
  output logic [MAG_W-1:0]      mag_y,
  output logic [MAG_W-1:0]      mag_z,
  output logic [SQ_W-1:0]       sum_sq,
  output logic [3*NW+4:0]       side
);

  localparam int PRW = NW + COEF_W;
  localparam int RW  = PRW + 2;
  localparam int PB  = $clog2(RW);
  localparam int XW  = RW + MAG_W - 1;

  logic signed [NW-1:0] n_in [3];
  logic [ROW_W-1:0]     rows [3];

  logic [6:0]           vld;
  logic signed [NW-1:0] n1 [3];
  logic signed [NW-1:0] n2 [3];
  logic signed [NW-1:0] n3 [3];
  logic signed [NW-1:0] n4 [3];
  logic signed [NW-1:0] n5 [3];
  logic signed [NW-1:0] n6 [3];
  logic signed [NW-1:0] n7 [3];
  logic [6:0]           nok;
  logic [2:0]           sg3, sg4, sg5, sg6, sg7;
  logic                 zr4, zr5, zr6, zr7;

  logic signed [PRW-1:0] prd1 [3][3];
  logic signed [RW-1:0]  r2 [3];
  logic [RW-1:0]         mag3 [3];
  logic [RW-1:0]         mx3;
  logic [RW-1:0]         mag4 [3];
  logic [PB-1:0]         pos4;
  logic [MAG_W-1:0]      nm5 [3];
  logic [MAG_W-1:0]      nm6 [3];
  logic [MAG_W-1:0]      nm7 [3];
  logic [2*MAG_W-1:0]    sq6 [3];
  logic [SQ_W-1:0]       s27;

  logic [RW-1:0] mag_c [3];
  logic [RW-1:0] mx_c;
  logic [PB-1:0] pos_c;
  logic [XW-1:0] ext_c [3];

  assign n_in[0] = normal_x;
  assign n_in[1] = normal_y;
  assign n_in[2] = normal_z;
  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_vld};
    end
  end

  always_comb begin
    mx_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = r2[i][RW-1] ? RW'(-r2[i]) : RW'(r2[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (mag_c[i] > mx_c) mx_c = mag_c[i];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int k = 0; k < RW; k++) begin
      if (mx3[k]) pos_c = PB'(k);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext_c[i] = {mag4[i], {(MAG_W-1){1'b0}}} >> pos4;
    end
  end

  always_ff @(posedge clk) begin
    nok <= {nok[5:0], normal_ok};
    for (int i = 0; i < 3; i++) begin
      n1[i] <= n_in[i];
      n2[i] <= n1[i];
      n3[i] <= n2[i];
      n4[i] <= n3[i];
      n5[i] <= n4[i];
      n6[i] <= n5[i];
      n7[i] <= n6[i];
    end
    for (int o = 0; o < 3; o++) begin
      for (int i = 0; i < 3; i++) begin
        prd1[o][i] <= PRW'(coef_of(rows[o], 2 - i)) * PRW'(n_in[i]);
      end
      r2[o] <= RW'(prd1[o][0]) + RW'(prd1[o][1]) + RW'(prd1[o][2]);
    end
    for (int i = 0; i < 3; i++) begin
      sg3[i]  <= r2[i][RW-1];
      mag3[i] <= mag_c[i];
      mag4[i] <= mag3[i];
      nm5[i]  <= ext_c[i][MAG_W-1:0];
      nm6[i]  <= nm5[i];
      nm7[i]  <= nm6[i];
      sq6[i]  <= nm5[i] * nm5[i];
    end
    mx3  <= mx_c;
    pos4 <= pos_c;
    zr4  <= (mx3 == '0);
    zr5  <= zr4;
    zr6  <= zr5;
    zr7  <= zr6;
    sg4  <= sg3;
    sg5  <= sg4;
    sg6  <= sg5;
    sg7  <= sg6;
    s27  <= SQ_W'(sq6[0]) + SQ_W'(sq6[1]) + SQ_W'(sq6[2]);
  end

  assign out_vld = vld[6];
  assign mag_x   = nm7[0];
  assign mag_y   = nm7[1];
  assign mag_z   = nm7[2];
  assign sum_sq  = s27;
  assign side    = {n7[0], n7[1], n7[2], nok[6], zr7, sg7};

endmodule

// File: hw/rtl/apnt_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_isqrt
// Pipelined floor square root, one result bit per stage, with a side
// channel that travels alongside.
// ----------------------------------------------------------------------------
module apnt_isqrt import apnt_pkg::*; #(
  parameter int PASS_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [SQ_W-1:0]   radicand,
  input  logic [PASS_W-1:0] pass_in,
  output logic              out_vld,
  output logic [LEN_W-1:0]  root,
  output logic [PASS_W-1:0] pass_out
);

  logic              vq [ISQ_LAT];
  logic [SQ_W-1:0]   rem_q [ISQ_LAT];
  logic [SQ_W-1:0]   rt_q [ISQ_LAT];
  logic [PASS_W-1:0] ps_q [ISQ_LAT];

  for (genvar k = 0; k < ISQ_LAT; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_LAT - 1 - k));
    logic              v_i;
    logic [SQ_W-1:0]   rem_i;
    logic [SQ_W-1:0]   rt_i;
    logic [PASS_W-1:0] ps_i;
    logic [SQ_W-1:0]   trial;

    if (k == 0) begin : g_first
      assign v_i   = in_vld;
      assign rem_i = radicand;
      assign rt_i  = '0;
      assign ps_i  = pass_in;
    end else begin : g_next
      assign v_i   = vq[k-1];
      assign rem_i = rem_q[k-1];
      assign rt_i  = rt_q[k-1];
      assign ps_i  = ps_q[k-1];
    end

    assign trial = rt_i + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else begin
        vq[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      ps_q[k] <= ps_i;
      if (rem_i >= trial) begin
        rem_q[k] <= rem_i - trial;
        rt_q[k]  <= (rt_i >> 1) + BIT;
      end else begin
        rem_q[k] <= rem_i;
        rt_q[k]  <= rt_i >> 1;
      end
    end
  end

  assign out_vld  = vq[ISQ_LAT-1];
  assign root     = rt_q[ISQ_LAT-1][LEN_W-1:0];
  assign pass_out = ps_q[ISQ_LAT-1];

endmodule

// File: hw/rtl/apnt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_div
// Three-lane pipelined restoring divider: rounded mag * 2^frac / length,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module apnt_div import apnt_pkg::*; #(
  parameter int NW     = NORMAL_W_DEF,
  parameter int PASS_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [MAG_W-1:0]  mag_x,
  input  logic [MAG_W-1:0]  mag_y,
  input  logic [MAG_W-1:0]  mag_z,
  input  logic [LEN_W-1:0]  len,
  input  logic [PASS_W-1:0] pass_in,
  output logic              out_vld,
  output logic [NW-2:0]     quo_x,
  output logic [NW-2:0]     quo_y,
  output logic [NW-2:0]     quo_z,
  output logic [PASS_W-1:0] pass_out
);

  localparam int NFRAC = NW - 2;
  localparam int QB    = NW - 1;
  localparam int DW    = MAG_W + NFRAC + 1;

  logic [MAG_W-1:0]  mag_in [3];
  logic [DW-1:0]     dvd_c [3];

  logic              vq [QB+1];
  logic [LEN_W-1:0]  len_q [QB+1];
  logic [PASS_W-1:0] ps_q [QB+1];
  logic [LEN_W-1:0]  rem_q [QB+1][3];
  logic [QB-1:0]     low_q [QB+1][3];
  logic [QB-1:0]     quo_q [QB+1][3];

  assign mag_in[0] = mag_x;
  assign mag_in[1] = mag_y;
  assign mag_in[2] = mag_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dvd_c[j] = (DW'(mag_in[j]) << NFRAC) + DW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else begin
      vq[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    len_q[0] <= len;
    ps_q[0]  <= pass_in;
    for (int j = 0; j < 3; j++) begin
      rem_q[0][j] <= LEN_W'(dvd_c[j] >> QB);
      low_q[0][j] <= dvd_c[j][QB-1:0];
      quo_q[0][j] <= '0;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [LEN_W:0] trial [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = {rem_q[s-1][j], low_q[s-1][j][QB-s]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[s] <= 1'b0;
      end else begin
        vq[s] <= vq[s-1];
      end
    end

    always_ff @(posedge clk) begin
      len_q[s] <= len_q[s-1];
      ps_q[s]  <= ps_q[s-1];
      for (int j = 0; j < 3; j++) begin
        low_q[s][j] <= low_q[s-1][j];
        if (trial[j] >= {1'b0, len_q[s-1]}) begin
          rem_q[s][j] <= LEN_W'(trial[j] - {1'b0, len_q[s-1]});
          quo_q[s][j] <= {quo_q[s-1][j][QB-2:0], 1'b1};
        end else begin
          rem_q[s][j] <= trial[j][LEN_W-1:0];
          quo_q[s][j] <= {quo_q[s-1][j][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vq[QB];
  assign quo_x    = quo_q[QB][0];
  assign quo_y    = quo_q[QB][1];
  assign quo_z    = quo_q[QB][2];
  assign pass_out = ps_q[QB];

endmodule

// File: hw/rtl/affine_point_normal_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_normal_transform
// Applies a 3x4 affine matrix to surface points and the 3x3 part to their
// normals, renormalizing each normal to unit length.
//
// Usage:
//   Configuration: write a register with wr_en, wr_index and wr_data while
//   no transaction is in flight. Reset loads the identity matrix, zero
//   translation, zero offset and offset disabled, and empties the pipeline.
//   Input: a transaction is taken at each clock edge with start high; busy
//   is tied low, so one transaction can enter every cycle.
//   Output: each result shows on the result ports for one cycle with done
//   high, in input order. The receiver cannot stall; the pipeline never
//   holds.
//   Pipeline: from the edge that takes start to the edge that sets done, a
//   transaction passes rotation (7 stages), square root (31 stages),
//   divider (NORMAL_WIDTH stages) and the output register.
//   Throughput: one transaction per cycle.
// ----------------------------------------------------------------------------
module affine_point_normal_transform import apnt_pkg::*; #(
  parameter int POINT_WIDTH  = POINT_W_DEF,
  parameter int NORMAL_WIDTH = NORMAL_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [CFG_IDX_W-1:0]           wr_index,
  input  logic [PACK3_W-1:0]             wr_data,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [POINT_WIDTH-1:0]  point_x,
  input  logic signed [POINT_WIDTH-1:0]  point_y,
  input  logic signed [POINT_WIDTH-1:0]  point_z,
  input  logic                           point_ok,
  input  logic signed [NORMAL_WIDTH-1:0] normal_x,
  input  logic signed [NORMAL_WIDTH-1:0] normal_y,
  input  logic signed [NORMAL_WIDTH-1:0] normal_z,
  input  logic                           normal_ok,
  output logic                           done,
  output logic signed [POINT_WIDTH-1:0]  out_x,
  output logic signed [POINT_WIDTH-1:0]  out_y,
  output logic signed [POINT_WIDTH-1:0]  out_z,
  output logic                           out_point_ok,
  output logic signed [NORMAL_WIDTH-1:0] dir_x,
  output logic signed [NORMAL_WIDTH-1:0] dir_y,
  output logic signed [NORMAL_WIDTH-1:0] dir_z,
  output logic                           out_normal_ok
);

  localparam int NW      = NORMAL_WIDTH;
  localparam int QB      = NW - 1;
  localparam int SIDE_W  = 3 * NW + 5;
  localparam int ISQ_PW  = SIDE_W + 3 * MAG_W;
  localparam int NRM_LAT = ROT_LAT + ISQ_LAT + QB + 1;
  localparam int DLY     = NRM_LAT - PNT_LAT;
  localparam int LAT     = NRM_LAT + 1;

  xform_cfg_t cfg;

  logic                          acc;
  logic signed [POINT_WIDTH-1:0] px, py, pz;
  logic                          pok;

  logic               rot_vld;
  logic [MAG_W-1:0]   rot_mag [3];
  logic [SQ_W-1:0]    rot_sq;
  logic [SIDE_W-1:0]  rot_side;

  logic               isq_vld;
  logic [LEN_W-1:0]   isq_root;
  logic [ISQ_PW-1:0]  isq_pass;

  logic               div_vld;
  logic [QB-1:0]      quo [3];
  logic [SIDE_W-1:0]  div_side;

  logic signed [NW-1:0] orig [3];
  logic                 s_nok, s_zr;
  logic [2:0]           s_sg;
  logic signed [NW-1:0] dir_c [3];
  logic signed [NW-1:0] qv;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_z  <= ROW_Z_RST;
      cfg.row_y  <= ROW_Y_RST;
      cfg.row_x  <= ROW_X_RST;
      cfg.trans  <= '0;
      cfg.offset <= '0;
      cfg.off_en <= 1'b0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_ROW_Z:  cfg.row_z  <= wr_data[ROW_W-1:0];
        REG_ROW_Y:  cfg.row_y  <= wr_data[ROW_W-1:0];
        REG_ROW_X:  cfg.row_x  <= wr_data[ROW_W-1:0];
        REG_TRANS:  cfg.trans  <= wr_data;
        REG_OFFSET: cfg.offset <= wr_data;
        REG_OFF_EN: cfg.off_en <= wr_data[0];
        default: ;
      endcase
    end
  end

  apnt_point #(
    .PW  (POINT_WIDTH),
    .DLY (DLY)
  ) u_point (
    .clk      (clk),
    .cfg      (cfg),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .point_ok (point_ok),
    .res_x    (px),
    .res_y    (py),
    .res_z    (pz),
    .res_ok   (pok)
  );

  apnt_rotate #(
    .NW (NW)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (acc),
    .cfg       (cfg),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .normal_ok (normal_ok),
    .out_vld   (rot_vld),
    .mag_x     (rot_mag[0]),
    .mag_y     (rot_mag[1]),
    .mag_z     (rot_mag[2]),
    .sum_sq    (rot_sq),
    .side      (rot_side)
  );

  apnt_isqrt #(
    .PASS_W (ISQ_PW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rot_vld),
    .radicand (rot_sq),
    .pass_in  ({rot_side, rot_mag[0], rot_mag[1], rot_mag[2]}),
    .out_vld  (isq_vld),
    .root     (isq_root),
    .pass_out (isq_pass)
  );

  apnt_div #(
    .NW     (NW),
    .PASS_W (SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (isq_vld),
    .mag_x    (isq_pass[3*MAG_W-1:2*MAG_W]),
    .mag_y    (isq_pass[2*MAG_W-1:MAG_W]),
    .mag_z    (isq_pass[MAG_W-1:0]),
    .len      (isq_root),
    .pass_in  (isq_pass[ISQ_PW-1:3*MAG_W]),
    .out_vld  (div_vld),
    .quo_x    (quo[0]),
    .quo_y    (quo[1]),
    .quo_z    (quo[2]),
    .pass_out (div_side)
  );

  assign orig[0] = div_side[SIDE_W-1 -: NW];
  assign orig[1] = div_side[SIDE_W-1-NW -: NW];
  assign orig[2] = div_side[SIDE_W-1-2*NW -: NW];
  assign s_nok   = div_side[4];
  assign s_zr    = div_side[3];
  assign s_sg    = div_side[2:0];

  always_comb begin
    qv = '0;
    for (int i = 0; i < 3; i++) begin
      qv = {1'b0, quo[i]};
      if (!s_nok || s_zr) dir_c[i] = orig[i];
      else if (s_sg[i]) dir_c[i] = -qv;
      else dir_c[i] = qv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_x         <= px;
    out_y         <= py;
    out_z         <= pz;
    out_point_ok  <= pok;
    dir_x         <= dir_c[0];
    dir_y         <= dir_c[1];
    dir_z         <= dir_c[2];
    out_normal_ok <= s_nok;
  end

`ifndef ASSERT_OFF
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching transaction");

  a_point_bypass: assert property (@(posedge clk) disable iff (rst)
    (done && !out_point_ok) |->
      (out_x == $past(point_x, LAT) && out_z == $past(point_z, LAT)))
    else $error("invalid point not passed through");

  a_normal_bypass: assert property (@(posedge clk) disable iff (rst)
    (done && !out_normal_ok) |->
      (dir_x == $past(normal_x, LAT) && dir_y == $past(normal_y, LAT)))
    else $error("invalid normal not passed through");

  a_flags_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_point_ok == $past(point_ok, LAT) &&
              out_normal_ok == $past(normal_ok, LAT)))
    else $error("valid flags misaligned with transaction");
`endif

endmodule
